### sv/mlfq_pkg.sv
// ----------------------------------------------------------------------------
// mlfq_pkg
// Shared types and constants for the three-level feedback scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package mlfq_pkg;

    // Fixed field widths of the channels and the register port
    localparam int JOB_ID_W   = 8;
    localparam int BURST_W    = 16;
    localparam int TIME_W     = 32;
    localparam int QUANTUM_W  = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int NUM_LEVELS = 3;

    // Input command codes
    typedef enum logic {
        CMD_ARRIVE = 1'b0,
        CMD_TICK   = 1'b1
    } cmd_t;

    // Register indexes (byte address = 4 * index)
    typedef enum logic {
        REG_QUANTUM_FIRST  = 1'b0,
        REG_QUANTUM_SECOND = 1'b1
    } reg_idx_t;

    // Level of the running job; zero only out of reset
    typedef logic [1:0] level_t;
    localparam level_t LEVEL_NONE  = 2'd0;
    localparam level_t LEVEL_ONE   = 2'd1;
    localparam level_t LEVEL_TWO   = 2'd2;
    localparam level_t LEVEL_THREE = 2'd3;

    localparam logic [QUANTUM_W-1:0] QUANTUM_FIRST_RESET  = 16'd8;
    localparam logic [QUANTUM_W-1:0] QUANTUM_SECOND_RESET = 16'd16;

    // A zero quantum behaves as a quantum of one
    function automatic logic [QUANTUM_W-1:0] quantum_or_one(input logic [QUANTUM_W-1:0] q);
        return (q == '0) ? QUANTUM_W'(1) : q;
    endfunction

endpackage

`default_nettype wire

### sv/mlfq_job_if.sv
// ----------------------------------------------------------------------------
// mlfq_job_if
// Job channel: arrival and tick commands into the scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

interface mlfq_job_if;
    logic                                  valid;
    logic                                  ready;
    mlfq_pkg::cmd_t                        command;
    logic [mlfq_pkg::JOB_ID_W-1:0]         job_id;
    logic [mlfq_pkg::BURST_W-1:0]          burst;

    modport source (output valid, command, job_id, burst, input ready);
    modport sink   (input valid, command, job_id, burst, output ready);
endinterface

`default_nettype wire

### sv/mlfq_seg_if.sv
// ----------------------------------------------------------------------------
// mlfq_seg_if
// Segment channel: one word per finished or expired run segment.
// ----------------------------------------------------------------------------
`default_nettype none

interface mlfq_seg_if;
    logic                                  valid;
    logic                                  ready;
    logic [mlfq_pkg::JOB_ID_W-1:0]         seg_job;
    logic [mlfq_pkg::TIME_W-1:0]           seg_start;
    logic [mlfq_pkg::TIME_W-1:0]           seg_end;
    logic                                  finished;
    logic                                  overflow;

    modport source (output valid, seg_job, seg_start, seg_end, finished, overflow,
                    input ready);
    modport sink   (input valid, seg_job, seg_start, seg_end, finished, overflow,
                    output ready);
endinterface

`default_nettype wire

### sv/multilevel_feedback_queue_scheduler_core.sv
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler_core
// Three-level non-preemptive feedback scheduler with a segment output.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      word
//  job_in    in   valid/ready    command, job_id, burst
//  seg_out   out  valid/ready    seg_job, seg_start, seg_end, finished, overflow
//  apb       in   psel/penable   quantum_first (0x0), quantum_second (0x4)
//
//  One word per cycle unless the stage stalls: an accepted word is held in the
//  input stage and is processed in a single pass (queue push, head pop,
//  counters) into the state and the segment register. A segment is presented
//  at the edge at which its tick leaves the input stage. The input stage stalls
//  only while a segment is held in the output register and not taken. Reset is
//  asynchronous; queue contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module multilevel_feedback_queue_scheduler_core #(
    parameter int MAX_JOBS   = 16,
    parameter int ID_BITS    = 8,
    parameter int BURST_BITS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [mlfq_pkg::CFG_ADDR_W-1:0]     paddr,
    input  wire logic [mlfq_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic      [mlfq_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                     pready,
    mlfq_job_if.sink                                 job_in,
    mlfq_seg_if.source                               seg_out
);

    // Stored widths: the channel fields cap the parameters
    localparam int ID_W    = (ID_BITS < mlfq_pkg::JOB_ID_W) ? ID_BITS : mlfq_pkg::JOB_ID_W;
    localparam int LEFT_W  = (BURST_BITS < mlfq_pkg::BURST_W) ? BURST_BITS : mlfq_pkg::BURST_W;
    localparam int ENTRY_W = ID_W + LEFT_W;
    localparam int IDX_W   = $clog2(MAX_JOBS);
    localparam int CNT_W   = $clog2(MAX_JOBS + 1);
    localparam int NL      = mlfq_pkg::NUM_LEVELS;
    localparam int QW      = mlfq_pkg::QUANTUM_W;
    localparam int TW      = mlfq_pkg::TIME_W;

    // Configuration registers
    logic [QW-1:0] quantum_first_reg;
    logic [QW-1:0] quantum_second_reg;

    // Input stage
    logic                 stage_valid_reg, stage_valid_next;
    mlfq_pkg::cmd_t       stage_cmd_reg;
    logic [ID_W-1:0]      stage_id_reg;
    logic [LEFT_W-1:0]    stage_burst_reg;

    // Level FIFOs and their pointers
    logic [ENTRY_W-1:0]   queue_mem [NL][MAX_JOBS];
    logic [IDX_W-1:0]     head_reg  [NL];
    logic [IDX_W-1:0]     head_next [NL];
    logic [CNT_W-1:0]     count_reg [NL];
    logic [CNT_W-1:0]     count_next[NL];

    // Scheduler state
    logic                 running_reg, running_next;
    logic [ID_W-1:0]      run_job_reg, run_job_next;
    logic [LEFT_W-1:0]    run_left_reg, run_left_next;
    mlfq_pkg::level_t     run_level_reg, run_level_next;
    logic [QW-1:0]        slice_left_reg, slice_left_next;
    logic [TW-1:0]        seg_start_reg, seg_start_next;
    logic [TW-1:0]        now_reg, now_next;
    logic [CNT_W-1:0]     live_reg, live_next;
    logic                 overflow_reg, overflow_next;

    // Output register
    logic                 out_valid_reg, out_valid_next;
    logic [ID_W-1:0]      out_job_reg;
    logic [TW-1:0]        out_start_reg;
    logic [TW-1:0]        out_end_reg;
    logic                 out_finished_reg;
    logic                 out_overflow_reg;

    // Single-pass datapath signals
    logic                 step;
    logic                 emit;
    logic                 done;
    logic                 push_en;
    logic [1:0]           push_q;
    logic [ENTRY_W-1:0]   push_data;
    logic [IDX_W-1:0]     push_idx;
    logic [CNT_W:0]       tail_sum;
    logic                 dispatch;
    logic                 pop_en;
    logic [1:0]           pop_q;
    logic [ENTRY_W-1:0]   pop_data;
    logic [ENTRY_W-1:0]   head_data[NL];
    logic [NL-1:0]        avail;
    logic [LEFT_W-1:0]    arr_left;
    logic [LEFT_W-1:0]    left_dec;
    logic [QW-1:0]        slice_dec;

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_first_reg  <= mlfq_pkg::QUANTUM_FIRST_RESET;
            quantum_second_reg <= mlfq_pkg::QUANTUM_SECOND_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            case (mlfq_pkg::reg_idx_t'(paddr[2]))
                mlfq_pkg::REG_QUANTUM_FIRST:  quantum_first_reg  <= pwdata[QW-1:0];
                mlfq_pkg::REG_QUANTUM_SECOND: quantum_second_reg <= pwdata[QW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (mlfq_pkg::reg_idx_t'(paddr[2]))
            mlfq_pkg::REG_QUANTUM_FIRST:  prdata = mlfq_pkg::CFG_DATA_W'(quantum_first_reg);
            mlfq_pkg::REG_QUANTUM_SECOND: prdata = mlfq_pkg::CFG_DATA_W'(quantum_second_reg);
            default:                      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshakes: the stage moves on unless a held segment blocks it
    // ------------------------------------------------------------------
    assign step         = stage_valid_reg && (!out_valid_reg || seg_out.ready);
    assign job_in.ready = !stage_valid_reg || step;

    assign stage_valid_next = job_in.valid ? 1'b1 : (stage_valid_reg && !step);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (job_in.valid && job_in.ready)
        begin
            stage_cmd_reg   <= job_in.command;
            stage_id_reg    <= job_in.job_id[ID_W-1:0];
            stage_burst_reg <= job_in.burst[LEFT_W-1:0];
        end
    end

    // FIFO heads, read at one address per level
    always_comb
    begin
        for (int k = 0; k < NL; k++)
            head_data[k] = queue_mem[k][head_reg[k]];
    end

    // ------------------------------------------------------------------
    // Scheduler step: arrival or tick, then dispatch
    // ------------------------------------------------------------------
    always_comb
    begin
        running_next    = running_reg;
        run_job_next    = run_job_reg;
        run_left_next   = run_left_reg;
        run_level_next  = run_level_reg;
        slice_left_next = slice_left_reg;
        seg_start_next  = seg_start_reg;
        now_next        = now_reg;
        live_next       = live_reg;
        overflow_next   = overflow_reg;
        emit            = 1'b0;
        done            = 1'b0;
        push_en         = 1'b0;
        push_q          = 2'd0;
        push_data       = '0;
        dispatch        = 1'b0;

        arr_left  = (stage_burst_reg == '0) ? LEFT_W'(1) : stage_burst_reg;
        left_dec  = run_left_reg - LEFT_W'(1);
        slice_dec = slice_left_reg - QW'(1);

        if (stage_cmd_reg == mlfq_pkg::CMD_ARRIVE)
        begin
            // arrival joins level one, or is dropped when full
            if (live_reg >= CNT_W'(MAX_JOBS))
                overflow_next = 1'b1;
            else
            begin
                live_next = live_reg + CNT_W'(1);
                push_en   = 1'b1;
                push_q    = 2'd0;
                push_data = {stage_id_reg, arr_left};
                dispatch  = !running_reg;
            end
        end
        else
        begin
            now_next = now_reg + TW'(1);
            if (!running_reg)
                dispatch = 1'b1;
            else if (left_dec == '0)
            begin
                // job completed
                emit      = 1'b1;
                done      = 1'b1;
                live_next = live_reg - CNT_W'(1);
            end
            else if (run_level_reg != mlfq_pkg::LEVEL_THREE && slice_dec == '0)
            begin
                // slice expired: demote to the next level
                emit      = 1'b1;
                push_en   = 1'b1;
                push_q    = run_level_reg;
                push_data = {run_job_reg, left_dec};
            end
            else
            begin
                run_left_next = left_dec;
                if (run_level_reg != mlfq_pkg::LEVEL_THREE)
                    slice_left_next = slice_dec;
            end
            if (emit)
            begin
                running_next = 1'b0;
                dispatch     = 1'b1;
            end
        end

        // highest non-empty level, counting a push made in this step
        for (int k = 0; k < NL; k++)
            avail[k] = (count_reg[k] != '0) || (push_en && push_q == 2'(k));
        pop_q = 2'd0;
        for (int k = NL - 1; k >= 0; k--)
        begin
            if (avail[k])
                pop_q = 2'(k);
        end
        pop_en   = dispatch && (avail != '0);
        pop_data = (count_reg[pop_q] == '0) ? push_data : head_data[pop_q];

        if (pop_en)
        begin
            running_next   = 1'b1;
            run_job_next   = pop_data[ENTRY_W-1:LEFT_W];
            run_left_next  = pop_data[LEFT_W-1:0];
            run_level_next = mlfq_pkg::level_t'(pop_q + 2'd1);
            seg_start_next = now_next;
            case (pop_q)
                2'd0:    slice_left_next = mlfq_pkg::quantum_or_one(quantum_first_reg);
                2'd1:    slice_left_next = mlfq_pkg::quantum_or_one(quantum_second_reg);
                default: slice_left_next = '0;
            endcase
        end
    end

    // Pointer update and push address
    always_comb
    begin
        tail_sum = (CNT_W+1)'(head_reg[push_q]) + (CNT_W+1)'(count_reg[push_q]);
        if (tail_sum >= (CNT_W+1)'(MAX_JOBS))
            tail_sum = tail_sum - (CNT_W+1)'(MAX_JOBS);
        push_idx = tail_sum[IDX_W-1:0];

        for (int k = 0; k < NL; k++)
        begin
            count_next[k] = count_reg[k];
            head_next[k]  = head_reg[k];
            if (push_en && push_q == 2'(k))
                count_next[k] = count_next[k] + CNT_W'(1);
            if (pop_en && pop_q == 2'(k))
            begin
                count_next[k] = count_next[k] - CNT_W'(1);
                head_next[k]  = (head_reg[k] == IDX_W'(MAX_JOBS - 1)) ? '0
                              : head_reg[k] + IDX_W'(1);
            end
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (step && push_en)
            queue_mem[push_q][push_idx] <= push_data;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NL; k++)
            begin
                head_reg[k]  <= '0;
                count_reg[k] <= '0;
            end
            running_reg    <= 1'b0;
            run_job_reg    <= '0;
            run_left_reg   <= '0;
            run_level_reg  <= mlfq_pkg::LEVEL_NONE;
            slice_left_reg <= '0;
            seg_start_reg  <= '0;
            now_reg        <= '0;
            live_reg       <= '0;
            overflow_reg   <= 1'b0;
        end
        else if (step)
        begin
            for (int k = 0; k < NL; k++)
            begin
                head_reg[k]  <= head_next[k];
                count_reg[k] <= count_next[k];
            end
            running_reg    <= running_next;
            run_job_reg    <= run_job_next;
            run_left_reg   <= run_left_next;
            run_level_reg  <= run_level_next;
            slice_left_reg <= slice_left_next;
            seg_start_reg  <= seg_start_next;
            now_reg        <= now_next;
            live_reg       <= live_next;
            overflow_reg   <= overflow_next;
        end
    end

    // ------------------------------------------------------------------
    // Segment output register
    // ------------------------------------------------------------------
    assign out_valid_next = (step && emit) ? 1'b1 : (out_valid_reg && !seg_out.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (step && emit)
        begin
            out_job_reg      <= run_job_reg;
            out_start_reg    <= seg_start_reg;
            out_end_reg      <= now_next;
            out_finished_reg <= done;
            out_overflow_reg <= overflow_reg;
        end
    end

    assign seg_out.valid     = out_valid_reg;
    assign seg_out.seg_job   = mlfq_pkg::JOB_ID_W'(out_job_reg);
    assign seg_out.seg_start = out_start_reg;
    assign seg_out.seg_end   = out_end_reg;
    assign seg_out.finished  = out_finished_reg;
    assign seg_out.overflow  = out_overflow_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // live count never exceeds capacity
    a_live_cap: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= CNT_W'(MAX_JOBS))
        else $error("live job count above capacity");

    // queued jobs plus the running one make up the live count
    a_live_sum: assert property (@(posedge clk) disable iff (!rst_n)
        ((CNT_W+2)'(count_reg[0]) + (CNT_W+2)'(count_reg[1]) + (CNT_W+2)'(count_reg[2])
         + (CNT_W+2)'(running_reg)) == (CNT_W+2)'(live_reg))
        else $error("queue counts disagree with live count");

    // idle implies every level is empty
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !running_reg |-> (count_reg[0] == '0 && count_reg[1] == '0 && count_reg[2] == '0))
        else $error("scheduler idle with queued jobs");

    // a running job always has work left
    a_run_left: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |-> (run_left_reg != '0 && run_level_reg != mlfq_pkg::LEVEL_NONE))
        else $error("running job with no work left");

endmodule

`default_nettype wire

### tb/sv/tb_multilevel_feedback_queue_scheduler_core.sv
// ----------------------------------------------------------------------------
// tb_multilevel_feedback_queue_scheduler_core
// Self-checking bench for the three-level feedback scheduler.
// Arrival and tick words go in on the job channel; an in-bench model of the
// scheduler (three job FIFOs, slice counters, time and the sticky overflow
// flag) predicts every run segment, and each segment word that leaves the
// block is checked field by field against the oldest prediction. Quanta are
// rewritten over the APB port between phases, after every segment is out.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_multilevel_feedback_queue_scheduler_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int JOB_SLOTS = 16;

    // One segment word as seen on the output channel
    typedef struct packed {
        logic [mlfq_pkg::JOB_ID_W-1:0] job;
        logic [mlfq_pkg::TIME_W-1:0]   t_begin;
        logic [mlfq_pkg::TIME_W-1:0]   t_end;
        logic                          done;
        logic                          ovf;
    } segment_t;

    // One queued job: id and run time still owed
    typedef struct packed {
        logic [mlfq_pkg::JOB_ID_W-1:0] job;
        logic [mlfq_pkg::BURST_W-1:0]  left;
    } job_entry_t;

    // ------------------------------------------------------------------------
    // Scheduler model and segment scoreboard
    // ------------------------------------------------------------------------
    class segment_tracker;
        int unsigned                    slots;
        logic [mlfq_pkg::QUANTUM_W-1:0] slice_first;
        logic [mlfq_pkg::QUANTUM_W-1:0] slice_second;
        job_entry_t                     lvl1[$];
        job_entry_t                     lvl2[$];
        job_entry_t                     lvl3[$];
        int unsigned                    jobs_live;
        bit                             busy;
        logic [mlfq_pkg::JOB_ID_W-1:0]  cur_job;
        logic [mlfq_pkg::BURST_W-1:0]   cur_left;
        logic [mlfq_pkg::QUANTUM_W-1:0] slice_left;
        mlfq_pkg::level_t               cur_level;
        logic [mlfq_pkg::TIME_W-1:0]    seg_begin;
        logic [mlfq_pkg::TIME_W-1:0]    now_t;
        bit                             overflow_seen;
        segment_t                       segments_due[$];
        int unsigned                    errors;

        function new(int unsigned n);
            slots         = n;
            slice_first   = mlfq_pkg::QUANTUM_FIRST_RESET;
            slice_second  = mlfq_pkg::QUANTUM_SECOND_RESET;
            jobs_live     = 0;
            busy          = 1'b0;
            cur_job       = '0;
            cur_left      = '0;
            slice_left    = '0;
            cur_level     = mlfq_pkg::LEVEL_NONE;
            seg_begin     = '0;
            now_t         = '0;
            overflow_seen = 1'b0;
            errors        = 0;
        endfunction

        function void set_quantum(mlfq_pkg::reg_idx_t idx,
                                  logic [mlfq_pkg::QUANTUM_W-1:0] val);
            if (idx == mlfq_pkg::REG_QUANTUM_FIRST)
                slice_first = val;
            else
                slice_second = val;
        endfunction

        // Take the head of the highest non-empty level, if any
        function void start_next();
            job_entry_t e;
            if (lvl1.size() != 0)
            begin
                e          = lvl1.pop_front();
                cur_level  = mlfq_pkg::LEVEL_ONE;
                slice_left = (slice_first == '0) ? 16'd1 : slice_first;
            end
            else if (lvl2.size() != 0)
            begin
                e          = lvl2.pop_front();
                cur_level  = mlfq_pkg::LEVEL_TWO;
                slice_left = (slice_second == '0) ? 16'd1 : slice_second;
            end
            else if (lvl3.size() != 0)
            begin
                e          = lvl3.pop_front();
                cur_level  = mlfq_pkg::LEVEL_THREE;
                slice_left = '0;
            end
            else
                return;
            busy      = 1'b1;
            cur_job   = e.job;
            cur_left  = e.left;
            seg_begin = now_t;
        endfunction

        // Apply one accepted job-channel word
        function void take_word(mlfq_pkg::cmd_t cmd, logic [mlfq_pkg::JOB_ID_W-1:0] id,
                                logic [mlfq_pkg::BURST_W-1:0] burst);
            segment_t   seg;
            job_entry_t e;
            bit         done;
            if (cmd == mlfq_pkg::CMD_ARRIVE)
            begin
                if (jobs_live >= slots)
                begin
                    overflow_seen = 1'b1;
                    return;
                end
                e.job  = id;
                e.left = (burst == '0) ? 16'd1 : burst;
                lvl1   = {lvl1, e};
                jobs_live++;
                if (!busy)
                    start_next();
                return;
            end

            now_t = now_t + 1'b1;
            if (!busy)
            begin
                start_next();
                return;
            end
            cur_left = cur_left - 1'b1;
            if (cur_level != mlfq_pkg::LEVEL_THREE)
                slice_left = slice_left - 1'b1;
            if (cur_left == '0)
            begin
                done = 1'b1;
                if (jobs_live != 0)
                    jobs_live--;
            end
            else if (cur_level != mlfq_pkg::LEVEL_THREE && slice_left == '0)
            begin
                // slice used up: demote one level
                done   = 1'b0;
                e.job  = cur_job;
                e.left = cur_left;
                if (cur_level == mlfq_pkg::LEVEL_ONE)
                    lvl2 = {lvl2, e};
                else
                    lvl3 = {lvl3, e};
            end
            else
                return;
            seg.job      = cur_job;
            seg.t_begin  = seg_begin;
            seg.t_end    = now_t;
            seg.done     = done;
            seg.ovf      = overflow_seen;
            segments_due = {segments_due, seg};
            busy = 1'b0;
            start_next();
        endfunction

        function void check_segment(segment_t got);
            segment_t want;
            if (segments_due.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected segment: job %0d start %0d end %0d fin %0d ovf %0d",
                             got.job, got.t_begin, got.t_end, got.done, got.ovf);
                return;
            end
            want = segments_due.pop_front();
            if (got.job !== want.job || got.t_begin !== want.t_begin ||
                got.t_end !== want.t_end || got.done !== want.done ||
                got.ovf !== want.ovf)
            begin
                errors++;
                if (errors <= 10)
                    $display("segment mismatch: exp job %0d start %0d end %0d fin %0d ovf %0d,",
                             want.job, want.t_begin, want.t_end, want.done, want.ovf,
                             " got job %0d start %0d end %0d fin %0d ovf %0d",
                             got.job, got.t_begin, got.t_end, got.done, got.ovf);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals, channels and the block
    // ------------------------------------------------------------------------
    logic                            clk     = 1'b0;
    logic                            rst_n   = 1'b0;
    logic                            psel    = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite  = 1'b0;
    logic [mlfq_pkg::CFG_ADDR_W-1:0] paddr   = '0;
    logic [mlfq_pkg::CFG_DATA_W-1:0] pwdata  = '0;
    logic [mlfq_pkg::CFG_DATA_W-1:0] prdata;
    logic                            pready;

    int unsigned gap_pct   = 0;
    int unsigned stall_pct = 0;

    segment_tracker sb = new(JOB_SLOTS);

    mlfq_job_if job_if ();
    mlfq_seg_if seg_if ();

    multilevel_feedback_queue_scheduler_core #(
        .MAX_JOBS   (JOB_SLOTS),
        .ID_BITS    (mlfq_pkg::JOB_ID_W),
        .BURST_BITS (mlfq_pkg::BURST_W)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .job_in  (job_if),
        .seg_out (seg_if)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Segment side: random back-pressure and the checker
    // ------------------------------------------------------------------------
    initial
    begin
        seg_if.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                seg_if.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            seg_if.ready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        segment_t got;
        if (rst_n && seg_if.valid && seg_if.ready)
        begin
            got.job     = seg_if.seg_job;
            got.t_begin = seg_if.seg_start;
            got.t_end   = seg_if.seg_end;
            got.done    = seg_if.finished;
            got.ovf     = seg_if.overflow;
            sb.check_segment(got);
        end
    end

    // ------------------------------------------------------------------------
    // Job side drivers
    // ------------------------------------------------------------------------
    // Present one word, with an optional idle burst first, and wait for it
    task automatic send_word(input mlfq_pkg::cmd_t cmd,
                             input logic [mlfq_pkg::JOB_ID_W-1:0] id,
                             input logic [mlfq_pkg::BURST_W-1:0] burst);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            job_if.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        job_if.valid   <= 1'b1;
        job_if.command <= cmd;
        job_if.job_id  <= id;
        job_if.burst   <= burst;
        do
            @(posedge clk);
        while (!job_if.ready);
        sb.take_word(cmd, id, burst);
    endtask

    // Hold off until every predicted segment is out, then let the pipe drain
    task automatic settle();
        job_if.valid <= 1'b0;
        while (sb.segments_due.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // Back-to-back APB writes of both quanta; junk in the unused upper bits
    task automatic write_quanta(input logic [mlfq_pkg::QUANTUM_W-1:0] q1,
                                input logic [mlfq_pkg::QUANTUM_W-1:0] q2);
        logic [mlfq_pkg::QUANTUM_W-1:0] val;
        for (int i = 0; i < 2; i++)
        begin
            val = (i == 0) ? q1 : q2;
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {mlfq_pkg::reg_idx_t'(i), 2'b00};
            pwdata  <= {16'($urandom), val};
            @(posedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (!pready);
            sb.set_quantum(mlfq_pkg::reg_idx_t'(i), val);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Mostly short jobs and ticks, arrivals throttled by the live count
    // unless flooding on purpose to hit the capacity limit
    task automatic random_items(input int count, input bit flood);
        mlfq_pkg::cmd_t               cmd;
        logic [mlfq_pkg::BURST_W-1:0] burst;
        int unsigned                  arrive_pct;
        int unsigned                  pick;
        for (int n = 0; n < count; n++)
        begin
            if (flood)
                arrive_pct = 70;
            else if (sb.jobs_live >= JOB_SLOTS)
                arrive_pct = 0;
            else if (sb.jobs_live < 4)
                arrive_pct = 40;
            else if (sb.jobs_live < 12)
                arrive_pct = 15;
            else
                arrive_pct = 5;
            cmd  = ($urandom_range(0, 99) < arrive_pct) ? mlfq_pkg::CMD_ARRIVE
                                                        : mlfq_pkg::CMD_TICK;
            pick = $urandom_range(0, 99);
            if (pick < 4)
                burst = '0;
            else if (pick < 80)
                burst = 16'($urandom_range(1, 12));
            else if (pick < 95)
                burst = 16'($urandom_range(13, 40));
            else
                burst = 16'($urandom_range(41, 160));
            send_word(cmd, 8'($urandom), burst);
        end
    endtask

    task automatic run_phase(input logic [mlfq_pkg::QUANTUM_W-1:0] q1,
                             input logic [mlfq_pkg::QUANTUM_W-1:0] q2,
                             input int count, input bit flood);
        settle();
        write_quanta(q1, q2);
        case ($urandom_range(0, 2))
            0: gap_pct = 0;
            1: gap_pct = 3;
            default: gap_pct = 10;
        endcase
        case ($urandom_range(0, 2))
            0: stall_pct = 0;
            1: stall_pct = 3;
            default: stall_pct = 10;
        endcase
        random_items(count, flood);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        job_if.valid   <= 1'b0;
        job_if.command <= mlfq_pkg::CMD_TICK;
        job_if.job_id  <= '0;
        job_if.burst   <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset quanta, idle tick, zero burst dispatched on arrival
        gap_pct   = 5;
        stall_pct = 5;
        send_word(mlfq_pkg::CMD_TICK, '0, '0);
        send_word(mlfq_pkg::CMD_ARRIVE, 8'h00, 16'h0000);
        send_word(mlfq_pkg::CMD_TICK, '0, '0);

        // directed: tiny quanta, several arrivals in one time unit, demotion
        // through all three levels, completion exactly at slice end
        settle();
        write_quanta(16'd1, 16'd2);
        send_word(mlfq_pkg::CMD_ARRIVE, 8'hFF, 16'd5);
        send_word(mlfq_pkg::CMD_ARRIVE, 8'h5A, 16'd1);
        send_word(mlfq_pkg::CMD_ARRIVE, 8'hA5, 16'd2);
        repeat (8) send_word(mlfq_pkg::CMD_TICK, '0, '0);
        send_word(mlfq_pkg::CMD_ARRIVE, 8'h3C, 16'd3);
        repeat (4) send_word(mlfq_pkg::CMD_TICK, '0, '0);

        // random phases over a spread of quanta, extremes included
        run_phase(16'd1,     16'd1,     200, 1'b0);
        run_phase(16'd2,     16'd3,     200, 1'b0);
        run_phase(16'hFFFF,  16'hFFFF,  200, 1'b0);
        run_phase(16'd0,     16'd0,     200, 1'b0);
        run_phase(16'd1,     16'hFFFF,  200, 1'b0);
        run_phase(16'hFFFF,  16'd1,     200, 1'b0);
        run_phase(16'd3,     16'd5,     200, 1'b0);
        run_phase(16'd4,     16'd7,     150, 1'b1);

        // last stretch with no idling on either side
        settle();
        write_quanta(16'd2, 16'd4);
        gap_pct   = 0;
        stall_pct = 0;
        random_items(150, 1'b0);
        // long bursts only at the very end, where they cannot hold up checks
        send_word(mlfq_pkg::CMD_ARRIVE, 8'hFF, 16'hFFFF);
        send_word(mlfq_pkg::CMD_ARRIVE, 8'h00, 16'h8000);
        send_word(mlfq_pkg::CMD_ARRIVE, 8'($urandom), 16'h7FFF);
        send_word(mlfq_pkg::CMD_ARRIVE, 8'($urandom), 16'($urandom));
        repeat (6) send_word(mlfq_pkg::CMD_TICK, '0, '0);

        settle();
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(5_000_000);
        $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
sv/mlfq_pkg.sv
sv/mlfq_job_if.sv
sv/mlfq_seg_if.sv
sv/multilevel_feedback_queue_scheduler_core.sv
tb/sv/tb_multilevel_feedback_queue_scheduler_core.sv
